[rtl/rfns_pkg.sv]
// ============================================================================
// rfns_pkg
// Shared types and constants for the RAM file node store.
// ============================================================================
package rfns_pkg;

    localparam int NAME_W = 48;
    localparam int RIDX_W = 5;
    localparam int BOUT_W = 9;

    localparam logic [RIDX_W-1:0] RIDX_NONE = '1;
    localparam logic [BOUT_W-1:0] BYTE_EOF  = '1;
    localparam logic [NAME_W-1:0] DOT_NAME  = NAME_W'(8'h2E);

    typedef enum logic [2:0] {
        MODE_CREATE  = 3'd0,
        MODE_LINK    = 3'd1,
        MODE_UNLINK  = 3'd2,
        MODE_GRAB    = 3'd3,
        MODE_RELEASE = 3'd4,
        MODE_WRITE   = 3'd5,
        MODE_READ    = 3'd6,
        MODE_LOOKUP  = 3'd7
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_MISSING = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef struct packed {
        logic              used;
        logic [NAME_W-1:0] name;
    } entry_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_res_t;

    // Root directory table: entry 0 is ".", the rest unused.
    function automatic entry_t dir_entry(input int unsigned idx);
        entry_t e;
        e.used = (idx == 0);
        e.name = (idx == 0) ? DOT_NAME : '0;
        return e;
    endfunction

endpackage

[rtl/rfns_ram.sv]
// ============================================================================
// rfns_ram
// Simple dual-port synchronous RAM, one write and one read port, registered
// read data.
// ============================================================================
module rfns_ram #(
    parameter  int DEPTH  = 8,
    parameter  int DATA_W = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rfns_dir_scan.sv]
// ============================================================================
// rfns_dir_scan
// Directory lookup: trims the name, then walks the root directory table one
// entry per cycle and reports the lowest used entry that matches.
// ============================================================================
module rfns_dir_scan #(
    parameter  int DIR_ENTRIES = 16,
    parameter  int NAME_CHARS  = 6,
    localparam int IDX_W       = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [rfns_pkg::NAME_W-1:0] name,
    output rfns_pkg::scan_res_t       res,
    output logic [IDX_W-1:0]          index
);

    import rfns_pkg::*;

    logic [NAME_W-1:0] key;
    logic              stop;
    logic [NAME_W-1:0] key_reg;
    logic              busy_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic              done_reg;
    logic              found_reg;
    logic [IDX_W-1:0]  index_reg;
    entry_t            cur_entry;
    logic              hit;
    logic              last;

    // keep the first NAME_CHARS characters, cut at the first zero
    always_comb begin
        key  = '0;
        stop = 1'b0;
        for (int i = 0; i < NAME_W / 8; i++) begin
            if (i < NAME_CHARS && !stop) begin
                if (name[8*i +: 8] == 8'd0) begin
                    stop = 1'b1;
                end else begin
                    key[8*i +: 8] = name[8*i +: 8];
                end
            end
        end
    end

    assign cur_entry = dir_entry(32'(idx_reg));
    assign hit       = cur_entry.used && (cur_entry.name == key_reg);
    assign last      = (idx_reg == IDX_W'(DIR_ENTRIES - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (hit || last)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            key_reg <= key;
            idx_reg <= '0;
        end else if (busy_reg) begin
            idx_reg   <= idx_reg + IDX_W'(1);
            found_reg <= hit;
            index_reg <= idx_reg;
        end
    end

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign index     = index_reg;

endmodule

[rtl/ram_file_node_store_core.sv]
// ============================================================================
// ram_file_node_store_core
// Small RAM file node store: node metadata and file bytes in two RAMs,
// one operation per item, one result item per input item.
// ============================================================================
// One item is worked at a time: it is registered, its metadata and data byte
// are read from RAM, then modified and written back. Link, unlink, grab,
// release, read and write are worked in S_EXEC; create then goes to S_CLEAR,
// where the new node's data bytes are zeroed one per cycle through the byte
// RAM write port; lookup goes to S_SCAN, one directory entry compared per
// cycle. A finished result sits in the output register while the next item
// is taken. After reset the block initializes the root node and zeroes its
// bytes before s_ready rises.
module ram_file_node_store_core #(
    parameter int NODE_SLOTS  = 8,
    parameter int DIR_ENTRIES = 16,
    parameter int BYTE_LIMIT  = 127,
    parameter int NAME_CHARS  = 6
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [2:0]                         s_mode,
    input  logic [2:0]                         s_node,
    input  logic [7:0]                         s_pos,
    input  logic [7:0]                         s_byte_in,
    input  logic [rfns_pkg::NAME_W-1:0]        s_lookup_name,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [rfns_pkg::RIDX_W-1:0] m_result_index,
    output logic signed [rfns_pkg::BOUT_W-1:0] m_byte_out,
    output logic                               m_byte_count,
    output logic [1:0]                         m_status
);

    import rfns_pkg::*;

    localparam int SLOT_W     = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int POS_W      = $clog2(BYTE_LIMIT + 1);
    localparam int SZ_MAX     = (BYTE_LIMIT < 256) ? BYTE_LIMIT : 256;
    localparam int SZ_W       = $clog2(SZ_MAX + 1);
    localparam int META_W     = 1 + SZ_W + 16;
    localparam int BYTE_DEPTH = (2 ** SLOT_W) * (2 ** POS_W);
    localparam int PCMP_W     = (POS_W > 8) ? POS_W + 1 : 9;
    localparam int DIDX_W     = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;

    typedef enum logic [7:0] {
        S_INIT  = 8'b0000_0001,
        S_CLEAR = 8'b0000_0010,
        S_IDLE  = 8'b0000_0100,
        S_ISSUE = 8'b0000_1000,
        S_EXEC  = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_SPARE = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [NODE_SLOTS-1:0]   slot_valid_reg, slot_valid_next;
    logic                    from_create_reg, from_create_next;
    logic [SLOT_W-1:0]       clr_slot_reg, clr_slot_next;
    logic [POS_W-1:0]        clr_cnt_reg, clr_cnt_next;

    mode_t                   mode_reg;
    logic [2:0]              node_reg;
    logic [7:0]              pos_reg;
    logic [7:0]              byte_in_reg;
    logic [NAME_W-1:0]       name_reg;

    logic [RIDX_W-1:0]       res_idx_reg, res_idx_next;
    logic [BOUT_W-1:0]       res_byte_reg, res_byte_next;
    logic                    res_cnt_reg, res_cnt_next;
    status_t                 res_st_reg, res_st_next;

    logic                    m_valid_reg, m_valid_next;
    logic [RIDX_W-1:0]       m_idx_reg;
    logic [BOUT_W-1:0]       m_byte_reg;
    logic                    m_cnt_reg;
    status_t                 m_st_reg;
    logic                    out_load;

    logic                    accept;
    logic [SLOT_W+2:0]       node_wide;
    logic [SLOT_W-1:0]       node_idx;
    logic                    node_ok;
    logic [PCMP_W-1:0]       pos_cmp;
    logic [POS_W-1:0]        pos_idx;
    logic                    range_ok;
    logic                    read_hit;
    logic [SZ_W-1:0]         size_new;

    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;

    logic                    meta_we;
    logic [SLOT_W-1:0]       meta_waddr;
    logic [META_W-1:0]       meta_wdata;
    logic [META_W-1:0]       meta_rdata;
    logic [7:0]              cur_ref, cur_link;
    logic [SZ_W-1:0]         cur_size;
    logic                    cur_dir;
    logic [7:0]              new_ref, new_link;

    logic                    byte_we;
    logic [SLOT_W+POS_W-1:0] byte_waddr;
    logic [7:0]              byte_wdata;
    logic [7:0]              byte_rdata;

    logic                    scan_start;
    scan_res_t               scan_res;
    logic [DIDX_W-1:0]       scan_index;

    rfns_ram #(
        .DEPTH  (NODE_SLOTS),
        .DATA_W (META_W)
    ) u_meta_ram (
        .aclk  (aclk),
        .we    (meta_we),
        .waddr (meta_waddr),
        .wdata (meta_wdata),
        .raddr (node_idx),
        .rdata (meta_rdata)
    );

    rfns_ram #(
        .DEPTH  (BYTE_DEPTH),
        .DATA_W (8)
    ) u_byte_ram (
        .aclk  (aclk),
        .we    (byte_we),
        .waddr (byte_waddr),
        .wdata (byte_wdata),
        .raddr ({node_idx, pos_idx}),
        .rdata (byte_rdata)
    );

    rfns_dir_scan #(
        .DIR_ENTRIES (DIR_ENTRIES),
        .NAME_CHARS  (NAME_CHARS)
    ) u_dir_scan (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (scan_start),
        .name    (name_reg),
        .res     (scan_res),
        .index   (scan_index)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign node_wide = (SLOT_W + 3)'(node_reg);
    assign node_idx  = node_wide[SLOT_W-1:0];
    assign node_ok   = (node_wide < (SLOT_W + 3)'(NODE_SLOTS)) && slot_valid_reg[node_idx];
    assign pos_cmp   = PCMP_W'(pos_reg);
    assign pos_idx   = pos_cmp[POS_W-1:0];
    assign range_ok  = (pos_cmp < PCMP_W'(BYTE_LIMIT));
    assign size_new  = SZ_W'({1'b0, pos_reg} + 9'd1);

    assign cur_ref  = meta_rdata[7:0];
    assign cur_link = meta_rdata[15:8];
    assign cur_size = meta_rdata[16 +: SZ_W];
    assign cur_dir  = meta_rdata[META_W-1];
    assign read_hit = ({1'b0, pos_reg} < 9'(cur_size));

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NODE_SLOTS - 1; i >= 0; i--) begin
            if (!slot_valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    always_comb begin
        state_next       = state_reg;
        slot_valid_next  = slot_valid_reg;
        from_create_next = from_create_reg;
        clr_slot_next    = clr_slot_reg;
        clr_cnt_next     = clr_cnt_reg;
        res_idx_next     = res_idx_reg;
        res_byte_next    = res_byte_reg;
        res_cnt_next     = res_cnt_reg;
        res_st_next      = res_st_reg;
        meta_we          = 1'b0;
        meta_waddr       = node_idx;
        meta_wdata       = meta_rdata;
        byte_we          = 1'b0;
        byte_waddr       = {node_idx, pos_idx};
        byte_wdata       = byte_in_reg;
        scan_start       = 1'b0;
        out_load         = 1'b0;
        new_ref          = cur_ref;
        new_link         = cur_link;

        unique case (state_reg)
            S_INIT: begin
                meta_we          = 1'b1;
                meta_waddr       = '0;
                meta_wdata       = {1'b1, {SZ_W{1'b0}}, 8'd1, 8'd0};
                clr_slot_next    = '0;
                clr_cnt_next     = '0;
                from_create_next = 1'b0;
                state_next       = S_CLEAR;
            end
            S_CLEAR: begin
                byte_we      = 1'b1;
                byte_waddr   = {clr_slot_reg, clr_cnt_reg};
                byte_wdata   = 8'd0;
                clr_cnt_next = clr_cnt_reg + POS_W'(1);
                if (clr_cnt_reg == POS_W'(BYTE_LIMIT - 1)) begin
                    from_create_next = 1'b0;
                    state_next       = from_create_reg ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE: begin
                state_next = S_EXEC;
            end
            S_EXEC: begin
                res_idx_next  = '0;
                res_byte_next = '0;
                res_cnt_next  = 1'b0;
                res_st_next   = ST_OK;
                state_next    = S_DONE;
                unique case (mode_reg)
                    MODE_CREATE: begin
                        if (free_found) begin
                            slot_valid_next[free_idx] = 1'b1;
                            meta_we          = 1'b1;
                            meta_waddr       = free_idx;
                            meta_wdata       = '0;
                            res_idx_next     = RIDX_W'(free_idx);
                            clr_slot_next    = free_idx;
                            clr_cnt_next     = '0;
                            from_create_next = 1'b1;
                            state_next       = S_CLEAR;
                        end else begin
                            res_idx_next = RIDX_NONE;
                            res_st_next  = ST_MISSING;
                        end
                    end
                    MODE_LINK, MODE_UNLINK, MODE_GRAB, MODE_RELEASE: begin
                        if (!node_ok) begin
                            res_idx_next = RIDX_NONE;
                            res_st_next  = ST_MISSING;
                        end else begin
                            res_idx_next = RIDX_W'(node_reg);
                            priority if (mode_reg == MODE_LINK) begin
                                new_link = cur_link + 8'd1;
                            end else if (mode_reg == MODE_UNLINK) begin
                                new_link = cur_link - 8'd1;
                            end else if (mode_reg == MODE_GRAB) begin
                                new_ref = cur_ref + 8'd1;
                            end else begin
                                new_ref = cur_ref - 8'd1;
                            end
                            meta_we    = 1'b1;
                            meta_wdata = {cur_dir, cur_size, new_link, new_ref};
                            if ((mode_reg == MODE_UNLINK || mode_reg == MODE_RELEASE)
                                && new_ref == 8'd0 && new_link == 8'd0) begin
                                slot_valid_next[node_idx] = 1'b0;
                            end
                        end
                    end
                    MODE_WRITE: begin
                        res_byte_next = BYTE_EOF;
                        if (!node_ok) begin
                            res_st_next = ST_MISSING;
                        end else if (!range_ok) begin
                            res_st_next = ST_RANGE;
                        end else begin
                            byte_we       = 1'b1;
                            meta_we       = 1'b1;
                            meta_wdata    = {cur_dir, size_new, cur_link, cur_ref};
                            res_byte_next = BOUT_W'(byte_in_reg);
                            res_cnt_next  = 1'b1;
                        end
                    end
                    MODE_READ: begin
                        res_byte_next = BYTE_EOF;
                        if (!node_ok) begin
                            res_st_next = ST_MISSING;
                        end else if (!range_ok) begin
                            res_st_next = ST_RANGE;
                        end else if (read_hit) begin
                            res_byte_next = BOUT_W'(byte_rdata);
                            res_cnt_next  = 1'b1;
                        end
                    end
                    MODE_LOOKUP: begin
                        res_idx_next = RIDX_NONE;
                        if (!node_ok || !cur_dir) begin
                            res_st_next = ST_MISSING;
                        end else begin
                            scan_start = 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                    default: begin
                        res_idx_next = RIDX_NONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (scan_res.done) begin
                    if (scan_res.found) begin
                        res_idx_next = RIDX_W'(scan_index);
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_INIT;
            slot_valid_reg  <= NODE_SLOTS'(1);
            from_create_reg <= 1'b0;
            clr_slot_reg    <= '0;
            clr_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            slot_valid_reg  <= slot_valid_next;
            from_create_reg <= from_create_next;
            clr_slot_reg    <= clr_slot_next;
            clr_cnt_reg     <= clr_cnt_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            mode_reg    <= mode_t'(s_mode);
            node_reg    <= s_node;
            pos_reg     <= s_pos;
            byte_in_reg <= s_byte_in;
            name_reg    <= s_lookup_name;
        end
        res_idx_reg  <= res_idx_next;
        res_byte_reg <= res_byte_next;
        res_cnt_reg  <= res_cnt_next;
        res_st_reg   <= res_st_next;
        if (out_load) begin
            m_idx_reg  <= res_idx_reg;
            m_byte_reg <= res_byte_reg;
            m_cnt_reg  <= res_cnt_reg;
            m_st_reg   <= res_st_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_result_index = m_idx_reg;
    assign m_byte_out     = m_byte_reg;
    assign m_byte_count   = m_cnt_reg;
    assign m_status       = m_st_reg;

`ifndef ASSERT_OFF
    a_accept_starts_read: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_ISSUE))
        else $error("accepted item did not start a metadata read");

    a_transfer_is_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_count) |-> (m_status == ST_OK && !m_byte_out[BOUT_W-1]))
        else $error("byte transfer reported with error status or EOF");

    a_scan_in_scan_state: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_res.done |-> (state_reg == S_SCAN))
        else $error("directory scan finished outside lookup");

    a_create_claims_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && mode_reg == MODE_CREATE && free_found)
        |=> slot_valid_reg[$past(free_idx)])
        else $error("create did not mark its slot valid");
`endif

endmodule
